// ===== rtl/core/lfia_pkg.sv =====
// Shared types and constants of the log-linear Fisher information accumulator.
`timescale 1ns / 1ps
`default_nettype none

package lfia_pkg;

   // Mantissa of the logarithm unit: Q1.30
   localparam int MANT_BITS     = 31;
   localparam int LOG_FRAC_BITS = 28;

   // ln 2 in Q.30
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   // Largest positive magnitude of a product term
   localparam logic [63:0] SAT63 = 64'h7FFF_FFFF_FFFF_FFFF;

   // Reset value of the slope register (1.0 in Q16.16)
   localparam logic [31:0] THETA_SLOPE_RESET = 32'd65536;

   // Product sequence, in issue order
   typedef enum logic [2:0] {
      OP_LOG_W,
      OP_GRAD_W,
      OP_LOG_SQ,
      OP_LOG_SQ_W,
      OP_LOG_GRAD,
      OP_LOG_GRAD_W,
      OP_GRAD_SQ,
      OP_GRAD_SQ_W
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       flag_err;
      logic       start;
      logic       mul_go;
      mul_op_type op;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic c_pos;
      logic last;
      logic calc_done;
      logic mul_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/lfia_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module lfia_ctrl
   import lfia_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  dp_status_type      status,
   output dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_CALC,
      S_MUL,
      S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   mul_op_type op_ff, op_in;

   // Take a request only while idle
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.c_pos) begin
               cmd.start = 1'b1;
               state_in  = S_CALC;
            end else begin
               cmd.flag_err = 1'b1;
               state_in     = status.last ? S_EMIT : S_IDLE;
            end
         end
         S_CALC: begin
            if (status.calc_done) begin
               op_in      = OP_LOG_W;
               cmd.mul_go = 1'b1;
               cmd.op     = OP_LOG_W;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            if (status.mul_done) begin
               if (op_ff == OP_GRAD_SQ_W) begin
                  state_in = status.last ? S_EMIT : S_IDLE;
               end else begin
                  op_in      = mul_op_type'(op_ff + 3'd1);
                  cmd.mul_go = 1'b1;
                  cmd.op     = op_in;
               end
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_LOG_W;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lfia_dp.sv =====
// Datapath: logarithm, divider, shared multiplier, saturating sums and result register.
`timescale 1ns / 1ps
`default_nettype none

module lfia_dp
   import lfia_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int ACC_WIDTH  = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  dp_cmd_type                        cmd,
   output dp_status_type                     status,
   input  wire logic signed [DATA_WIDTH-1:0] req_x_value,
   input  wire logic        [16:0]           req_weight,
   input  wire logic                         req_last_point,
   input  wire logic signed [DATA_WIDTH-1:0] theta_slope,
   input  wire logic signed [DATA_WIDTH-1:0] theta_shift,
   input  wire logic                         rsp_stall,
   output logic                              rsp_valid,
   output logic signed [63:0]                rsp_sum_weight,
   output logic signed [63:0]                rsp_sum_weight_log,
   output logic signed [63:0]                rsp_sum_weight_grad,
   output logic        [62:0]                rsp_sum_weight_log_sq,
   output logic signed [63:0]                rsp_sum_weight_log_grad,
   output logic        [62:0]                rsp_sum_weight_grad_sq,
   output logic                              rsp_domain_error
);

   localparam int CW  = DATA_WIDTH + 1;          // width of c
   localparam int NW  = CW + MANT_BITS;          // normalizing word
   localparam int EW  = $clog2(CW);              // leading-one position
   localparam int NB  = DATA_WIDTH + 32;         // quotient bits
   localparam int QW  = (NB > 64) ? NB : 64;
   localparam int DCW = $clog2(NB);
   localparam logic signed [65:0] ACC_MAX = (66'sd1 <<< (ACC_WIDTH - 1)) - 66'sd1;
   localparam logic signed [65:0] ACC_MIN = -ACC_MAX - 66'sd1;

   typedef enum logic [2:0] {
      L_IDLE,
      L_NORM,
      L_SQ,
      L_MAG,
      L_SCALE
   } log_step_type;

   // Captured request
   logic [CW-1:0] c_ff;
   logic [16:0]   w_ff;
   logic          last_ff;
   logic [CW-1:0] c_in;

   assign c_in = {req_x_value[DATA_WIDTH-1], req_x_value}
               + {theta_shift[DATA_WIDTH-1], theta_shift};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         c_ff    <= c_in;
         w_ff    <= req_weight;
         last_ff <= req_last_point;
      end
   end

   // Logarithm: normalize, then square and compare one fraction bit a cycle, then scale by ln 2
   log_step_type         lstep_ff;
   logic                 log_ok_ff;
   logic [NW-1:0]        nw_ff;
   logic [EW-1:0]        ecnt_ff;
   logic [MANT_BITS-1:0] m_ff;
   logic [LOG_FRAC_BITS-1:0] f_ff;
   logic [4:0]           lcnt_ff;
   logic [33:0]          l2mag_ff;
   logic                 lneg_ff;
   logic [37:0]          lmag_ff;
   logic [61:0]          sq;
   logic [31:0]          sq_top;
   logic signed [35:0]   l2;
   logic [35:0]          l2abs;
   logic [63:0]          scaled;

   assign sq     = m_ff * m_ff;
   assign sq_top = sq[61:30];
   assign l2     = ((36'(ecnt_ff) - 36'd16) <<< LOG_FRAC_BITS) + 36'(f_ff);
   assign l2abs  = l2[35] ? (36'd0 - l2) : l2;
   assign scaled = l2mag_ff * LN2_Q30;

   always_ff @(posedge clock) begin
      if (reset) begin
         lstep_ff  <= L_IDLE;
         log_ok_ff <= 1'b0;
      end else if (cmd.start) begin
         nw_ff     <= {c_ff, {MANT_BITS{1'b0}}};
         ecnt_ff   <= EW'(CW - 1);
         f_ff      <= '0;
         lcnt_ff   <= '0;
         log_ok_ff <= 1'b0;
         lstep_ff  <= L_NORM;
      end else begin
         unique case (lstep_ff)
            L_IDLE: ;
            L_NORM: begin
               if (nw_ff[NW-1]) begin
                  m_ff     <= nw_ff[NW-1 -: MANT_BITS];
                  lstep_ff <= L_SQ;
               end else begin
                  nw_ff   <= nw_ff << 1;
                  ecnt_ff <= ecnt_ff - EW'(1);
               end
            end
            L_SQ: begin
               m_ff    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
               f_ff    <= {f_ff[LOG_FRAC_BITS-2:0], sq_top[31]};
               lcnt_ff <= lcnt_ff + 5'd1;
               if (lcnt_ff == 5'(LOG_FRAC_BITS - 1)) begin
                  lstep_ff <= L_MAG;
               end
            end
            L_MAG: begin
               l2mag_ff <= l2abs[33:0];
               lneg_ff  <= l2[35];
               lstep_ff <= L_SCALE;
            end
            L_SCALE: begin
               lmag_ff   <= scaled[63:26];
               log_ok_ff <= 1'b1;
               lstep_ff  <= L_IDLE;
            end
            default: lstep_ff <= L_IDLE;
         endcase
      end
   end

   // Divider: restoring, one quotient bit a cycle
   logic                  div_run_ff, div_ok_ff;
   logic [NB-1:0]         dq_ff;
   logic [CW-1:0]         r_ff;
   logic [DCW-1:0]        dcnt_ff;
   logic                  gneg_ff;
   logic [DATA_WIDTH-1:0] tmag;
   logic [CW:0]           rs, rdiff;
   logic                  rge;
   logic [QW-1:0]         qx;
   logic [63:0]           gmag;

   assign tmag  = theta_slope[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - theta_slope) : theta_slope;
   assign rs    = {r_ff, dq_ff[NB-1]};
   assign rdiff = rs - {1'b0, c_ff};
   assign rge   = (rs >= {1'b0, c_ff});
   assign qx    = QW'(dq_ff);
   assign gmag  = (|qx[QW-1:63]) ? SAT63 : {1'b0, qx[62:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff <= 1'b0;
         div_ok_ff  <= 1'b0;
      end else if (cmd.start) begin
         dq_ff      <= {tmag, 32'd0};
         r_ff       <= '0;
         dcnt_ff    <= '0;
         gneg_ff    <= theta_slope[DATA_WIDTH-1];
         div_run_ff <= 1'b1;
         div_ok_ff  <= 1'b0;
      end else if (div_run_ff) begin
         r_ff    <= rge ? rdiff[CW-1:0] : rs[CW-1:0];
         dq_ff   <= {dq_ff[NB-2:0], rge};
         dcnt_ff <= dcnt_ff + DCW'(1);
         if (dcnt_ff == DCW'(NB - 1)) begin
            div_run_ff <= 1'b0;
            div_ok_ff  <= 1'b1;
         end
      end
   end

   // Shared multiplier: four 32x32 partial products into a 128-bit sum
   logic        mbusy_ff;
   logic [2:0]  mc_ff;
   mul_op_type  mop_ff;
   logic [63:0] a_ff, b_ff, a_sel, b_sel;
   logic        sh32_ff, sh32_sel;
   logic [63:0] pp_ff, pp_in;
   logic [1:0]  ppk_ff;
   logic [127:0] macc_ff, pp_shift;
   logic [63:0] lmag64, w64, mres;
   logic        mul_done;

   assign lmag64 = 64'(lmag_ff);
   assign w64    = 64'(w_ff);

   // Weighted second-order terms take the product that finishes in this cycle
   always_comb begin
      unique case (cmd.op)
         OP_LOG_W:      begin a_sel = lmag64; b_sel = w64;    sh32_sel = 1'b0; end
         OP_GRAD_W:     begin a_sel = gmag;   b_sel = w64;    sh32_sel = 1'b0; end
         OP_LOG_SQ:     begin a_sel = lmag64; b_sel = lmag64; sh32_sel = 1'b1; end
         OP_LOG_GRAD:   begin a_sel = lmag64; b_sel = gmag;   sh32_sel = 1'b1; end
         OP_GRAD_SQ:    begin a_sel = gmag;   b_sel = gmag;   sh32_sel = 1'b1; end
         default:       begin a_sel = mres;   b_sel = w64;    sh32_sel = 1'b0; end
      endcase
   end

   assign pp_in = (mc_ff[1] ? a_ff[63:32] : a_ff[31:0]) * (mc_ff[0] ? b_ff[63:32] : b_ff[31:0]);

   always_comb begin
      unique case (ppk_ff)
         2'd0:    pp_shift = {64'd0, pp_ff};
         2'd1:    pp_shift = {32'd0, pp_ff, 32'd0};
         default: pp_shift = {pp_ff, 64'd0};
      endcase
   end

   assign mul_done = mbusy_ff && (mc_ff == 3'd5);

   // Shift down, truncate, saturate at 2^63-1
   always_comb begin
      if (sh32_ff) begin
         mres = (|macc_ff[127:95]) ? SAT63 : {1'b0, macc_ff[94:32]};
      end else begin
         mres = (|macc_ff[127:79]) ? SAT63 : {1'b0, macc_ff[78:16]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
      end else if (cmd.mul_go) begin
         a_ff     <= a_sel;
         b_ff     <= b_sel;
         sh32_ff  <= sh32_sel;
         mop_ff   <= cmd.op;
         mc_ff    <= '0;
         macc_ff  <= '0;
         mbusy_ff <= 1'b1;
      end else if (mbusy_ff) begin
         if (!mc_ff[2]) begin
            pp_ff  <= pp_in;
            ppk_ff <= 2'(mc_ff[1]) + 2'(mc_ff[0]);
         end
         if (mc_ff != 3'd0 && mc_ff != 3'd5) begin
            macc_ff <= macc_ff + pp_shift;
         end
         mc_ff <= mc_ff + 3'd1;
         if (mul_done) begin
            mbusy_ff <= 1'b0;
         end
      end
   end

   // Saturating add into an accumulator
   function automatic logic [ACC_WIDTH-1:0] acc_sat(input logic [ACC_WIDTH-1:0] a,
                                                     input logic signed [63:0] t);
      logic signed [65:0] s;
      s = 66'($signed(a)) + 66'(t);
      if (s > ACC_MAX) begin
         acc_sat = ACC_MAX[ACC_WIDTH-1:0];
      end else if (s < ACC_MIN) begin
         acc_sat = ACC_MIN[ACC_WIDTH-1:0];
      end else begin
         acc_sat = s[ACC_WIDTH-1:0];
      end
   endfunction

   logic [ACC_WIDTH-1:0] sums_ff [6];
   logic                 err_ff;
   logic                 term_neg;
   logic signed [63:0]   term;
   logic signed [63:0]   w_term;

   always_comb begin
      unique case (mop_ff)
         OP_LOG_W:      term_neg = lneg_ff;
         OP_GRAD_W:     term_neg = gneg_ff;
         OP_LOG_GRAD_W: term_neg = lneg_ff ^ gneg_ff;
         default:       term_neg = 1'b0;
      endcase
   end

   assign term   = term_neg ? -$signed(mres) : $signed(mres);
   assign w_term = $signed({31'd0, w_ff, 16'd0});

   // Write back products; clear when a result is taken into the output register
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         for (int k = 0; k < 6; k++) begin
            sums_ff[k] <= '0;
         end
         err_ff <= 1'b0;
      end else begin
         if (cmd.flag_err) begin
            err_ff <= 1'b1;
         end
         if (mul_done) begin
            unique case (mop_ff)
               OP_LOG_W: begin
                  sums_ff[0] <= acc_sat(sums_ff[0], w_term);
                  sums_ff[1] <= acc_sat(sums_ff[1], term);
               end
               OP_GRAD_W:     sums_ff[2] <= acc_sat(sums_ff[2], term);
               OP_LOG_SQ_W:   sums_ff[3] <= acc_sat(sums_ff[3], term);
               OP_LOG_GRAD_W: sums_ff[4] <= acc_sat(sums_ff[4], term);
               OP_GRAD_SQ_W:  sums_ff[5] <= acc_sat(sums_ff[5], term);
               default: ;
            endcase
         end
      end
   end

   // Result register
   logic               rsp_valid_ff;
   logic signed [63:0] ext [6];

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         ext[k] = 64'($signed(sums_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_sum_weight          <= ext[0];
         rsp_sum_weight_log      <= ext[1];
         rsp_sum_weight_grad     <= ext[2];
         rsp_sum_weight_log_sq   <= ext[3][62:0];
         rsp_sum_weight_log_grad <= ext[4];
         rsp_sum_weight_grad_sq  <= ext[5][62:0];
         rsp_domain_error        <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Status to the controller
   assign status.c_pos     = !c_ff[CW-1] && (c_ff != '0);
   assign status.last      = last_ff;
   assign status.calc_done = log_ok_ff && div_ok_ff;
   assign status.mul_done  = mul_done;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

// ===== rtl/core/loglinear_fisher_info_accumulator_unit.sv =====
// Top level: configuration registers, controller and datapath.
//
//   port group  direction  handshake            contents
//   req_*       in         req_valid/req_stall  x_value, weight, last_point
//   rsp_*       out        rsp_valid/rsp_stall  six Q48.16 sums, domain_error
//   csr_*       in/out     APB write/read       theta_slope (0), theta_shift (1)
//
// Per point, the bit-serial divider runs next to the logarithm, then eight products go
// through the shared 32x32 multiplier. A point with x + theta_shift <= 0 skips them and
// sets the domain error flag. A result waits in the output register while the next point
// is taken. Reset is synchronous; it clears the sums, the error flag, rsp_valid and
// theta_shift and sets theta_slope to 1.0.
`timescale 1ns / 1ps
`default_nettype none

module loglinear_fisher_info_accumulator_unit
   import lfia_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int ACC_WIDTH  = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [DATA_WIDTH-1:0] req_x_value,
   input  wire logic        [16:0]           req_weight,
   input  wire logic                         req_last_point,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [63:0]                rsp_sum_weight,
   output logic signed [63:0]                rsp_sum_weight_log,
   output logic signed [63:0]                rsp_sum_weight_grad,
   output logic        [62:0]                rsp_sum_weight_log_sq,
   output logic signed [63:0]                rsp_sum_weight_log_grad,
   output logic        [62:0]                rsp_sum_weight_grad_sq,
   output logic                              rsp_domain_error,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [((DATA_WIDTH > 32) ? 4 : 3)-1:0] csr_paddr,
   input  wire logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] csr_pwdata,
   output logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int PAW = (DATA_WIDTH > 32) ? 4 : 3;
   localparam int PDW = (DATA_WIDTH > 32) ? 64 : 32;
   localparam logic REG_THETA_SLOPE = 1'b0;
   localparam logic REG_THETA_SHIFT = 1'b1;

   logic signed [DATA_WIDTH-1:0] theta_slope_ff, theta_shift_ff;
   logic                         csr_write;
   logic                         csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[PAW-1];

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         theta_slope_ff <= DATA_WIDTH'(THETA_SLOPE_RESET);
         theta_shift_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_THETA_SLOPE: theta_slope_ff <= csr_pwdata[DATA_WIDTH-1:0];
            REG_THETA_SHIFT: theta_shift_ff <= csr_pwdata[DATA_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Read back configuration
   assign csr_prdata = (csr_index == REG_THETA_SLOPE) ? PDW'(theta_slope_ff)
                                                      : PDW'(theta_shift_ff);

   dp_cmd_type    cmd;
   dp_status_type status;

   lfia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lfia_dp #(
      .DATA_WIDTH (DATA_WIDTH),
      .ACC_WIDTH  (ACC_WIDTH)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_x_value             (req_x_value),
      .req_weight              (req_weight),
      .req_last_point          (req_last_point),
      .theta_slope             (theta_slope_ff),
      .theta_shift             (theta_shift_ff),
      .rsp_stall               (rsp_stall),
      .rsp_valid               (rsp_valid),
      .rsp_sum_weight          (rsp_sum_weight),
      .rsp_sum_weight_log      (rsp_sum_weight_log),
      .rsp_sum_weight_grad     (rsp_sum_weight_grad),
      .rsp_sum_weight_log_sq   (rsp_sum_weight_log_sq),
      .rsp_sum_weight_log_grad (rsp_sum_weight_log_grad),
      .rsp_sum_weight_grad_sq  (rsp_sum_weight_grad_sq),
      .rsp_domain_error        (rsp_domain_error)
   );

endmodule

`default_nettype wire
